// ===== rtl/tts_pkg.sv =====
// Shared types, constants and helper functions for the timer table scheduler.
`timescale 1ns / 1ps

package tts_pkg;

	// Table geometry
	localparam int NUM_SLOTS   = 16;
	localparam int TAG_WIDTH   = 16;
	localparam int MAX_RESULTS = 16;

	localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IDX_W      = $clog2(NUM_SLOTS + 1);
	localparam int FIRE_W     = $clog2(MAX_RESULTS + 1);

	// Field widths
	localparam int IN_IVL_W   = 24;
	localparam int IVL_W      = 23;
	localparam int TIME_W     = 32;
	localparam int TAG_OUT_W  = 16;
	localparam int SLOT_OUT_W = 4;
	localparam int KIND_W     = 3;

	// Command queue between front and back (power of two depth)
	localparam int QDEPTH = 2;
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	// Request class decided by the front end
	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_NEG,
		CMD_ZERO,
		CMD_ARM
	} cmd_cls_t;

	typedef struct packed {
		cmd_cls_t              cls;
		logic [IVL_W-1:0]      interval;
		logic                  periodic;
		logic [TAG_WIDTH-1:0]  tag;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// Result kinds
	typedef enum logic [KIND_W-1:0] {
		K_FIRED = 3'd0,
		K_ARMED = 3'd1,
		K_NEG   = 3'd2,
		K_FULL  = 3'd3,
		K_IDLE  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FLUSH
	} bk_state_t;

	// One table entry held in the slot memory
	typedef struct packed {
		logic                 periodic;
		logic [IVL_W-1:0]     interval;
		logic [TIME_W-1:0]    deadline;
		logic [TAG_WIDTH-1:0] tag;
	} slot_t;

	// Request tag to stored tag width
	function automatic logic [TAG_WIDTH-1:0] tag_from_in(input logic [TAG_OUT_W-1:0] t);
		logic [TAG_WIDTH+TAG_OUT_W-1:0] ext;
		ext = {{TAG_WIDTH{1'b0}}, t};
		return ext[TAG_WIDTH-1:0];
	endfunction

	// Stored tag to result tag width
	function automatic logic [TAG_OUT_W-1:0] tag_to_out(input logic [TAG_WIDTH-1:0] t);
		logic [TAG_WIDTH+TAG_OUT_W-1:0] ext;
		ext = {{TAG_OUT_W{1'b0}}, t};
		return ext[TAG_OUT_W-1:0];
	endfunction

	// Slot index masked to the result field
	function automatic logic [SLOT_OUT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+SLOT_OUT_W-1:0] ext;
		ext = {{SLOT_OUT_W{1'b0}}, s};
		return ext[SLOT_OUT_W-1:0];
	endfunction

endpackage

// ===== rtl/tts_front.sv =====
// Front end: takes requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module tts_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic signed [tts_pkg::IN_IVL_W-1:0] interval_ms,
	input  logic                                repeat_flag,
	input  logic [tts_pkg::TAG_OUT_W-1:0]       user_tag,
	input  logic                                pop,
	output tts_pkg::q_head_t                    head
);
	import tts_pkg::*;

	cmd_t             cmd_in;
	cmd_t             q_mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop_ok;

	// Classify the request
	always_comb begin
		cmd_in.interval = interval_ms[IVL_W-1:0];
		cmd_in.periodic = repeat_flag;
		cmd_in.tag      = tag_from_in(user_tag);
		if (!op) begin
			cmd_in.cls = CMD_TICK;
		end else if (interval_ms[IN_IVL_W-1]) begin
			cmd_in.cls = CMD_NEG;
		end else if (interval_ms == '0) begin
			cmd_in.cls = CMD_ZERO;
		end else begin
			cmd_in.cls = CMD_ARM;
		end
	end

	assign busy   = (cnt_q == CNT_W'(QDEPTH));
	assign push   = start && !busy;
	assign pop_ok = pop && (cnt_q != '0);

	// Queue control; pointers wrap naturally since the depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop_ok) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop_ok) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop_ok) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= cmd_in;
	end

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = q_mem_q[rd_ptr_q];

endmodule

// ===== rtl/tts_back.sv =====
// Back end: slot table, millisecond clock, arm handling and expiry walk.
`timescale 1ns / 1ps

module tts_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tts_pkg::q_head_t                 head,
	output logic                             pop,
	output logic                             strobe,
	output logic [tts_pkg::KIND_W-1:0]       kind,
	output logic [tts_pkg::TAG_OUT_W-1:0]    tag_out,
	output logic [tts_pkg::SLOT_OUT_W-1:0]   slot_out,
	output logic                             last
);
	import tts_pkg::*;

	bk_state_t              state_q, state_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [TIME_W-1:0]      now_q, now_d;
	logic [NUM_SLOTS-1:0]   valid_q, valid_d;
	logic [FIRE_W-1:0]      fire_cnt_q, fire_cnt_d;
	logic                   pend_v_q, pend_v_d;
	logic [TAG_WIDTH-1:0]   pend_tag_q, pend_tag_d;
	logic [SLOT_W-1:0]      pend_slot_q, pend_slot_d;

	logic                   o_stb_q, o_stb_d;
	kind_t                  o_kind_q, o_kind_d;
	logic [TAG_OUT_W-1:0]   o_tag_q, o_tag_d;
	logic [SLOT_OUT_W-1:0]  o_slot_q, o_slot_d;
	logic                   o_last_q, o_last_d;

	slot_t                  slot_mem [NUM_SLOTS];
	slot_t                  rd_data_q;
	slot_t                  mem_wdata;
	logic                   mem_we;
	logic [SLOT_W-1:0]      mem_waddr;
	logic [SLOT_W-1:0]      rd_addr;

	logic [SLOT_W-1:0]      free_slot;
	logic                   free_found;
	logic [IDX_W-1:0]       ev_idx;
	logic [SLOT_W-1:0]      ev_slot;
	logic [TIME_W-1:0]      diff;
	logic                   past;

	// Lowest free slot
	always_comb begin
		free_slot  = '0;
		free_found = 1'b0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot  = SLOT_W'(i);
				free_found = 1'b1;
			end
		end
	end

	// Walk addressing: read slot idx, evaluate slot idx-1 from registered data
	assign rd_addr = (idx_q < IDX_W'(NUM_SLOTS)) ? idx_q[SLOT_W-1:0] : '0;
	assign ev_idx  = idx_q - 1'b1;
	assign ev_slot = ev_idx[SLOT_W-1:0];
	assign diff    = rd_data_q.deadline - now_q;
	assign past    = diff[TIME_W-1];

	// Next state and outputs
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		now_d       = now_q;
		valid_d     = valid_q;
		fire_cnt_d  = fire_cnt_q;
		pend_v_d    = pend_v_q;
		pend_tag_d  = pend_tag_q;
		pend_slot_d = pend_slot_q;
		o_stb_d     = 1'b0;
		o_kind_d    = K_IDLE;
		o_tag_d     = '0;
		o_slot_d    = '0;
		o_last_d    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = free_slot;
		mem_wdata   = '0;
		pop         = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.cmd.cls)
						CMD_TICK: begin
							now_d      = now_q + 1'b1;
							idx_d      = '0;
							fire_cnt_d = '0;
							pend_v_d   = 1'b0;
							state_d    = S_WALK;
						end
						CMD_NEG: begin
							o_stb_d  = 1'b1;
							o_kind_d = K_NEG;
							o_tag_d  = tag_to_out(head.cmd.tag);
							o_last_d = 1'b1;
						end
						CMD_ZERO: begin
							o_stb_d  = 1'b1;
							o_kind_d = K_FIRED;
							o_tag_d  = tag_to_out(head.cmd.tag);
							o_last_d = 1'b1;
						end
						CMD_ARM: begin
							o_stb_d  = 1'b1;
							o_tag_d  = tag_to_out(head.cmd.tag);
							o_last_d = 1'b1;
							if (free_found) begin
								valid_d[free_slot] = 1'b1;
								mem_we             = 1'b1;
								mem_waddr          = free_slot;
								mem_wdata.periodic = head.cmd.periodic;
								mem_wdata.interval = head.cmd.interval;
								mem_wdata.deadline = now_q +
									{{(TIME_W-IVL_W){1'b0}}, head.cmd.interval};
								mem_wdata.tag      = head.cmd.tag;
								o_kind_d           = K_ARMED;
								o_slot_d           = slot_to_out(free_slot);
							end else begin
								o_kind_d = K_FULL;
							end
						end
						default: ;
					endcase
				end
			end

			S_WALK: begin
				// Fire a due slot; the previous hit goes out with last low
				if (idx_q != '0 && valid_q[ev_slot] && past &&
						fire_cnt_q < FIRE_W'(MAX_RESULTS)) begin
					if (pend_v_q) begin
						o_stb_d  = 1'b1;
						o_kind_d = K_FIRED;
						o_tag_d  = tag_to_out(pend_tag_q);
						o_slot_d = slot_to_out(pend_slot_q);
					end
					pend_v_d    = 1'b1;
					pend_tag_d  = rd_data_q.tag;
					pend_slot_d = ev_slot;
					fire_cnt_d  = fire_cnt_q + 1'b1;
					if (rd_data_q.periodic) begin
						mem_we             = 1'b1;
						mem_waddr          = ev_slot;
						mem_wdata          = rd_data_q;
						mem_wdata.deadline = now_q +
							{{(TIME_W-IVL_W){1'b0}}, rd_data_q.interval};
					end else begin
						valid_d[ev_slot] = 1'b0;
					end
				end
				if (idx_q == IDX_W'(NUM_SLOTS)) begin
					state_d = S_FLUSH;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end

			S_FLUSH: begin
				// Final result of the tick
				o_stb_d  = 1'b1;
				o_last_d = 1'b1;
				if (pend_v_q) begin
					o_kind_d = K_FIRED;
					o_tag_d  = tag_to_out(pend_tag_q);
					o_slot_d = slot_to_out(pend_slot_q);
				end
				pend_v_d = 1'b0;
				state_d  = S_IDLE;
			end

			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			now_q      <= '0;
			valid_q    <= '0;
			fire_cnt_q <= '0;
			pend_v_q   <= 1'b0;
			o_stb_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			now_q      <= now_d;
			valid_q    <= valid_d;
			fire_cnt_q <= fire_cnt_d;
			pend_v_q   <= pend_v_d;
			o_stb_q    <= o_stb_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pend_tag_q  <= pend_tag_d;
		pend_slot_q <= pend_slot_d;
		o_kind_q    <= o_kind_d;
		o_tag_q     <= o_tag_d;
		o_slot_q    <= o_slot_d;
		o_last_q    <= o_last_d;
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
		rd_data_q <= slot_mem[rd_addr];
	end

	assign strobe   = o_stb_q;
	assign kind     = o_kind_q;
	assign tag_out  = o_tag_q;
	assign slot_out = o_slot_q;
	assign last     = o_last_q;

	// Checks
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |=> o_stb_q && o_last_q)
		else $error("tick did not close with a last result");

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FIRE_W'(MAX_RESULTS))
		else $error("fire count beyond result limit");

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		o_stb_q && o_kind_q == K_IDLE |-> o_last_q && o_tag_q == '0 && o_slot_q == '0)
		else $error("empty tick result malformed");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == S_IDLE && head.valid)
		else $error("queue popped outside idle");

endmodule

// ===== rtl/timer_table_scheduler_core.sv =====
// Top level of the timer table scheduler: front end, request queue and back end.
//
//  channel  | handshake           | signals
//  ---------+---------------------+-------------------------------------------
//  request  | start & !busy       | op, interval_ms, repeat_flag, user_tag
//  result   | strobe (one cycle)  | kind, tag_out, slot_out, last
//
// Arm: the request is written to the queue, popped by the back end in S_IDLE and
// its result registered at the output. Tick: a pop in S_IDLE, a walk over the
// single registered read port of the slot memory (one slot per cycle plus one
// step to prime the read), a closing S_FLUSH state and the output register.
// The front queues two requests, so busy rises only when both are waiting.
// Reset clears time, slot valid bits and the queue; no clearing pass is needed.
// Results cannot be held off; each is shown for exactly one cycle.
`timescale 1ns / 1ps

module timer_table_scheduler_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic signed [tts_pkg::IN_IVL_W-1:0] interval_ms,
	input  logic                                repeat_flag,
	input  logic [tts_pkg::TAG_OUT_W-1:0]       user_tag,
	output logic                                strobe,
	output logic [tts_pkg::KIND_W-1:0]          kind,
	output logic [tts_pkg::TAG_OUT_W-1:0]       tag_out,
	output logic [tts_pkg::SLOT_OUT_W-1:0]      slot_out,
	output logic                                last
);
	import tts_pkg::*;

	q_head_t head;
	logic    pop;

	tts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.interval_ms (interval_ms),
		.repeat_flag (repeat_flag),
		.user_tag    (user_tag),
		.pop         (pop),
		.head        (head)
	);

	tts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.strobe   (strobe),
		.kind     (kind),
		.tag_out  (tag_out),
		.slot_out (slot_out),
		.last     (last)
	);

endmodule
